>>> src/line_line_intersection_3d_assert.svh
// Assertion macros used by the top-level file to check the pipeline.
// Each macro expects signals named clk and arst_n in the enclosing scope.
`ifndef LINE_LINE_INTERSECTION_3D_ASSERT_SVH
`define LINE_LINE_INTERSECTION_3D_ASSERT_SVH

// A condition that holds at every clock edge out of reset.
`define LLI_ASSERT(lbl, cond, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A condition that holds in the cycle after a trigger.
`define LLI_ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/lli3d_pkg.sv
package lli3d_pkg;

	// Default geometry of the coordinate and direction formats.
	localparam int COORD_WIDTH_D = 32;
	localparam int FRAC_BITS_D   = 16;

	// Configuration port.
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;
	localparam int CTOL_W     = 32;
	localparam int PTOL_W     = 16;

	localparam logic [CFG_IDX_W-1:0] REG_COPLANAR_TOL = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_PARALLEL_TOL = CFG_IDX_W'(1);

	// Divider steps resolved in each pipeline stage.
	localparam int STEPS_PER_STAGE = 2;

	typedef enum logic [1:0] {
		KIND_NONE     = 2'd0,
		KIND_POINT    = 2'd1,
		KIND_COINCIDE = 2'd2
	} kind_t;

	localparam int KIND_W = 2;

	// Direction width: sign, one integer bit and the fraction.
	function automatic int dir_w(int f);
		return f + 2;
	endfunction

	// Width of the signed numerator of beta.
	function automatic int num_w(int c, int f);
		return c + 2 * f + 12;
	endfunction

	// Width of the signed denominator cf*cf - 1.
	function automatic int den_w(int f);
		return 2 * f + 13;
	endfunction

	// Quotient bits kept; anything larger is clamped anyway.
	function automatic int quo_w(int c, int f);
		return c + f + 2;
	endfunction

	// Side data carried alongside the divider: kind, sign and overflow flags, Ob and Db.
	function automatic int side_w(int c, int f);
		return KIND_W + 2 + 3 * c + 3 * dir_w(f);
	endfunction

endpackage

>>> src/lli3d_if.sv
// Line pair input channel.
interface lli3d_in_if #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] a_origin_x;
	logic signed [COORD_WIDTH-1:0] a_origin_y;
	logic signed [COORD_WIDTH-1:0] a_origin_z;
	logic signed [FRAC_BITS+1:0]   a_dir_x;
	logic signed [FRAC_BITS+1:0]   a_dir_y;
	logic signed [FRAC_BITS+1:0]   a_dir_z;
	logic signed [COORD_WIDTH-1:0] b_origin_x;
	logic signed [COORD_WIDTH-1:0] b_origin_y;
	logic signed [COORD_WIDTH-1:0] b_origin_z;
	logic signed [FRAC_BITS+1:0]   b_dir_x;
	logic signed [FRAC_BITS+1:0]   b_dir_y;
	logic signed [FRAC_BITS+1:0]   b_dir_z;

	modport source (
		output valid, a_origin_x, a_origin_y, a_origin_z, a_dir_x, a_dir_y, a_dir_z,
		output b_origin_x, b_origin_y, b_origin_z, b_dir_x, b_dir_y, b_dir_z,
		input  ready
	);
	modport sink (
		input  valid, a_origin_x, a_origin_y, a_origin_z, a_dir_x, a_dir_y, a_dir_z,
		input  b_origin_x, b_origin_y, b_origin_z, b_dir_x, b_dir_y, b_dir_z,
		output ready
	);
endinterface

// Result channel.
interface lli3d_out_if #(
	parameter int COORD_WIDTH = 32
);
	logic                          valid;
	logic                          ready;
	logic [1:0]                    result_kind;
	logic signed [COORD_WIDTH-1:0] point_x;
	logic signed [COORD_WIDTH-1:0] point_y;
	logic signed [COORD_WIDTH-1:0] point_z;

	modport source (output valid, result_kind, point_x, point_y, point_z, input ready);
	modport sink   (input valid, result_kind, point_x, point_y, point_z, output ready);
endinterface

// Register write channel.
interface lli3d_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

>>> src/lli3d_front.sv
// Geometry front end: products, cross and dot sums, tolerance tests and
// the numerator and denominator of beta, over six register stages.
module lli3d_front import lli3d_pkg::*; #(
	parameter  int COORD_WIDTH = COORD_WIDTH_D,
	parameter  int FRAC_BITS   = FRAC_BITS_D,
	localparam int C    = COORD_WIDTH,
	localparam int F    = FRAC_BITS,
	localparam int DW   = dir_w(F),
	localparam int AW   = C + 1,
	localparam int NW   = 2 * DW + 1,
	localparam int CUW  = DW + AW + 1,
	localparam int CW   = 2 * DW + 2,
	localparam int CFW  = CW - F,
	localparam int DETW = NW + AW + 2,
	localparam int DENW = den_w(F),
	localparam int PW   = DW + AW + 2,
	localparam int NUMW = num_w(C, F),
	localparam int QB   = quo_w(C, F),
	localparam int SW   = side_w(C, F)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 valid_in,
	input  logic signed [C-1:0]  oa [3],
	input  logic signed [C-1:0]  ob [3],
	input  logic signed [DW-1:0] u [3],
	input  logic signed [DW-1:0] v [3],
	input  logic [CTOL_W-1:0]    ctol,
	input  logic [PTOL_W-1:0]    ptol,
	output logic                 valid_out,
	output logic [NUMW-1:0]      num_mag,
	output logic [DENW-1:0]      den_mag,
	output logic [SW-1:0]        side
);

	localparam logic signed [DENW-1:0] ONE_SQ = DENW'(1) << (2 * F);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic signed [AW-1:0]      ab_s1 [3];
	logic signed [C-1:0]       ob_s1 [3];
	logic signed [DW-1:0]      u_s1 [3];
	logic signed [DW-1:0]      v_s1d [3];

	logic signed [2*DW-1:0]    puv_s2 [3][3];
	logic signed [DW+AW-1:0]   pua_s2 [3][3];
	logic signed [DW+AW-1:0]   pav_s2 [3];
	logic signed [AW-1:0]      ab_s2 [3];
	logic signed [C-1:0]       ob_s2 [3];
	logic signed [DW-1:0]      v_s2d [3];

	logic signed [NW-1:0]      n_s3 [3];
	logic signed [CUW-1:0]     cu_s3 [3];
	logic signed [CW-1:0]      c_s3;
	logic signed [PW-1:0]      p_s3;
	logic signed [PW-1:0]      q_s3;
	logic signed [AW-1:0]      ab_s3 [3];
	logic signed [C-1:0]       ob_s3 [3];
	logic signed [DW-1:0]      v_s3d [3];

	logic signed [NW+AW-1:0]   dp_s4 [3];
	logic signed [2*CFW-1:0]   cfsq_s4;
	logic signed [PW+CFW-1:0]  qcf_s4;
	logic signed [PW-1:0]      p_s4;
	logic                      par_uv_s4, par_ua_s4;
	logic signed [C-1:0]       ob_s4 [3];
	logic signed [DW-1:0]      v_s4d [3];

	logic signed [DETW-1:0]    det_s5;
	logic signed [DENW-1:0]    den_s5;
	logic signed [NUMW-1:0]    num_s5;
	logic                      par_uv_s5, par_ua_s5;
	logic signed [C-1:0]       ob_s5 [3];
	logic signed [DW-1:0]      v_s5d [3];

	logic [NUMW-1:0]           num_mag_s6;
	logic [DENW-1:0]           den_mag_s6;
	logic [SW-1:0]             side_s6;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= valid_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Stage 1: origin difference.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				ab_s1[i] <= AW'(ob[i]) - AW'(oa[i]);
				ob_s1[i] <= ob[i];
				u_s1[i]  <= u[i];
				v_s1d[i] <= v[i];
			end
		end
	end

	// Stage 2: pairwise products of the directions and of u with the difference, and the difference times v per axis.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					puv_s2[i][j] <= u_s1[i] * v_s1d[j];
					pua_s2[i][j] <= u_s1[i] * ab_s1[j];
				end
				pav_s2[i] <= ab_s1[i] * v_s1d[i];
				ab_s2[i]  <= ab_s1[i];
				ob_s2[i]  <= ob_s1[i];
				v_s2d[i]  <= v_s1d[i];
			end
		end
	end

	// Stage 3: cross products and dot products.
	always_ff @(posedge clk) begin
		if (en) begin
			n_s3[0]  <= NW'(puv_s2[1][2]) - NW'(puv_s2[2][1]);
			n_s3[1]  <= NW'(puv_s2[2][0]) - NW'(puv_s2[0][2]);
			n_s3[2]  <= NW'(puv_s2[0][1]) - NW'(puv_s2[1][0]);
			cu_s3[0] <= CUW'(pua_s2[1][2]) - CUW'(pua_s2[2][1]);
			cu_s3[1] <= CUW'(pua_s2[2][0]) - CUW'(pua_s2[0][2]);
			cu_s3[2] <= CUW'(pua_s2[0][1]) - CUW'(pua_s2[1][0]);
			c_s3 <= CW'(puv_s2[0][0]) + CW'(puv_s2[1][1]) + CW'(puv_s2[2][2]);
			p_s3 <= PW'(pav_s2[0]) + PW'(pav_s2[1]) + PW'(pav_s2[2]);
			q_s3 <= PW'(pua_s2[0][0]) + PW'(pua_s2[1][1]) + PW'(pua_s2[2][2]);
			for (int i = 0; i < 3; i++) begin
				ab_s3[i] <= ab_s2[i];
				ob_s3[i] <= ob_s2[i];
				v_s3d[i] <= v_s2d[i];
			end
		end
	end

	// Stage 4 logic: truncated cosine and parallel tests.
	logic signed [CFW-1:0] cf_c;
	logic [NW-1:0]         nmag_c [3];
	logic [CUW-1:0]        cumag_c [3];
	logic                  par_uv_c, par_ua_c;

	always_comb begin
		cf_c = CFW'(c_s3 >>> F);
		par_uv_c = 1'b1;
		par_ua_c = 1'b1;
		for (int i = 0; i < 3; i++) begin
			nmag_c[i]  = NW'(n_s3[i][NW-1] ? -n_s3[i] : n_s3[i]);
			cumag_c[i] = CUW'(cu_s3[i][CUW-1] ? -cu_s3[i] : cu_s3[i]);
			if ((nmag_c[i] >> F) > ptol) begin
				par_uv_c = 1'b0;
			end
			if ((cumag_c[i] >> F) > ptol) begin
				par_ua_c = 1'b0;
			end
		end
	end

	// Stage 4: triple product terms, cf squared and q times cf.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dp_s4[i] <= n_s3[i] * ab_s3[i];
				ob_s4[i] <= ob_s3[i];
				v_s4d[i] <= v_s3d[i];
			end
			cfsq_s4   <= cf_c * cf_c;
			qcf_s4    <= q_s3 * cf_c;
			p_s4      <= p_s3;
			par_uv_s4 <= par_uv_c;
			par_ua_s4 <= par_ua_c;
		end
	end

	// Stage 5: determinant, denominator and numerator.
	always_ff @(posedge clk) begin
		if (en) begin
			det_s5 <= DETW'(dp_s4[0]) + DETW'(dp_s4[1]) + DETW'(dp_s4[2]);
			den_s5 <= DENW'(cfsq_s4) - ONE_SQ;
			num_s5 <= (NUMW'(p_s4) <<< F) - NUMW'(qcf_s4);
			par_uv_s5 <= par_uv_s4;
			par_ua_s5 <= par_ua_s4;
			for (int i = 0; i < 3; i++) begin
				ob_s5[i] <= ob_s4[i];
				v_s5d[i] <= v_s4d[i];
			end
		end
	end

	// Stage 6 logic: classification, magnitudes and quotient overflow.
	logic [DETW-1:0] detmag_c;
	logic [NUMW-1:0] nummag_c;
	logic [DENW-1:0] denmag_c;
	kind_t           kind_c;
	logic            ovf_c, neg_c;
	logic [SW-1:0]   side_c;

	always_comb begin
		detmag_c = DETW'(det_s5[DETW-1] ? -det_s5 : det_s5);
		nummag_c = NUMW'(num_s5[NUMW-1] ? -num_s5 : num_s5);
		denmag_c = DENW'(den_s5[DENW-1] ? -den_s5 : den_s5);
		neg_c    = num_s5[NUMW-1] ^ den_s5[DENW-1];
		ovf_c    = (nummag_c >> QB) >= NUMW'(denmag_c);
		if ((detmag_c >> (2 * F)) > DETW'(ctol)) begin
			kind_c = KIND_NONE;
		end else if (par_uv_s5) begin
			kind_c = par_ua_s5 ? KIND_COINCIDE : KIND_NONE;
		end else if (den_s5 == '0) begin
			kind_c = KIND_NONE;
		end else begin
			kind_c = KIND_POINT;
		end
		side_c = '0;
		side_c[SW-1 -: KIND_W] = kind_c;
		side_c[3*C+3*DW+1]     = neg_c;
		side_c[3*C+3*DW]       = ovf_c;
		for (int i = 0; i < 3; i++) begin
			side_c[3*DW+(2-i)*C +: C] = ob_s5[i];
			side_c[(2-i)*DW +: DW]    = v_s5d[i];
		end
	end

	// Stage 6: operands for the divider.
	always_ff @(posedge clk) begin
		if (en) begin
			num_mag_s6 <= nummag_c;
			den_mag_s6 <= denmag_c;
			side_s6    <= side_c;
		end
	end

	assign valid_out = v_s6;
	assign num_mag   = num_mag_s6;
	assign den_mag   = den_mag_s6;
	assign side      = side_s6;

endmodule

>>> src/lli3d_div.sv
// Pipelined restoring divider: a few quotient bits per stage, with side
// data carried along so that each quotient leaves with its own item.
module lli3d_div import lli3d_pkg::*; #(
	parameter  int NUMW = 76,
	parameter  int DENW = 45,
	parameter  int QB   = 50,
	parameter  int SW   = 124,
	parameter  int SPS  = STEPS_PER_STAGE,
	localparam int NST  = (QB + SPS - 1) / SPS
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            valid_in,
	input  logic [NUMW-1:0] dividend,
	input  logic [DENW-1:0] divisor,
	input  logic [SW-1:0]   side_in,
	output logic            valid_out,
	output logic [QB-1:0]   quotient,
	output logic [SW-1:0]   side_out
);

	logic            vld_s  [NST];
	logic [DENW:0]   rem_s  [NST];
	logic [QB-1:0]   low_s  [NST];
	logic [QB-1:0]   quo_s  [NST];
	logic [DENW-1:0] dvs_s  [NST];
	logic [SW-1:0]   side_s [NST];

	for (genvar k = 0; k < NST; k++) begin : g_stage
		logic            vld_in;
		logic [DENW:0]   rem_in;
		logic [QB-1:0]   low_in;
		logic [QB-1:0]   quo_in;
		logic [DENW-1:0] dvs_in;
		logic [SW-1:0]   sd_in;
		logic [DENW:0]   r, t;
		logic [QB-1:0]   l, q;

		// Stage source: the module inputs or the previous stage.
		if (k == 0) begin : g_first
			assign vld_in = valid_in;
			assign rem_in = (DENW + 1)'(dividend >> QB);
			assign low_in = QB'(dividend);
			assign quo_in = '0;
			assign dvs_in = divisor;
			assign sd_in  = side_in;
		end else begin : g_next
			assign vld_in = vld_s[k-1];
			assign rem_in = rem_s[k-1];
			assign low_in = low_s[k-1];
			assign quo_in = quo_s[k-1];
			assign dvs_in = dvs_s[k-1];
			assign sd_in  = side_s[k-1];
		end

		// Shift in SPS dividend bits, one per step, and subtract where the divisor fits.
		always_comb begin
			r = rem_in;
			l = low_in;
			q = quo_in;
			t = '0;
			for (int s = 0; s < SPS; s++) begin
				if (k * SPS + s < QB) begin
					t = {r[DENW-1:0], l[QB-1]};
					l = l << 1;
					q = q << 1;
					if (t >= {1'b0, dvs_in}) begin
						r    = t - {1'b0, dvs_in};
						q[0] = 1'b1;
					end else begin
						r = t;
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= r;
				low_s[k]  <= l;
				quo_s[k]  <= q;
				dvs_s[k]  <= dvs_in;
				side_s[k] <= sd_in;
			end
		end
	end

	assign valid_out = vld_s[NST-1];
	assign quotient  = quo_s[NST-1];
	assign side_out  = side_s[NST-1];

endmodule

>>> src/lli3d_back.sv
// Back end: signed and clamped beta, beta times Db, and the saturated point.
module lli3d_back import lli3d_pkg::*; #(
	parameter  int COORD_WIDTH = COORD_WIDTH_D,
	parameter  int FRAC_BITS   = FRAC_BITS_D,
	localparam int C   = COORD_WIDTH,
	localparam int F   = FRAC_BITS,
	localparam int DW  = dir_w(F),
	localparam int QB  = quo_w(C, F),
	localparam int SW  = side_w(C, F),
	localparam int PRW = QB + 1 + DW,
	localparam int PTW = PRW - F + 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                valid_in,
	input  logic [QB-1:0]       quotient,
	input  logic [SW-1:0]       side,
	output logic                valid_out,
	output kind_t               kind,
	output logic signed [C-1:0] point [3]
);

	localparam logic [QB-1:0]         LIM = QB'(1) << (C + F + 1);
	localparam logic signed [PTW-1:0] HI  = (PTW'(1) <<< (C - 1)) - PTW'(1);
	localparam logic signed [PTW-1:0] LO  = -HI - PTW'(1);

	kind_t               kind_c;
	logic                neg_c, ovf_c;
	logic signed [C-1:0]  ob_c [3];
	logic signed [DW-1:0] v_c [3];
	logic [QB-1:0]        mag_c;

	logic                 v_s1, v_s2, v_s3;
	logic signed [QB:0]   beta_s1;
	kind_t                kind_s1, kind_s2, kind_s3;
	logic signed [C-1:0]  ob_s1 [3];
	logic signed [C-1:0]  ob_s2 [3];
	logic signed [DW-1:0] v_s1d [3];
	logic signed [PRW-1:0] prod_s2 [3];
	logic signed [C-1:0]  pt_s3 [3];

	// Unpack the side data and clamp the quotient magnitude.
	always_comb begin
		kind_c = kind_t'(side[SW-1 -: KIND_W]);
		neg_c  = side[3*C+3*DW+1];
		ovf_c  = side[3*C+3*DW];
		for (int i = 0; i < 3; i++) begin
			ob_c[i] = side[3*DW+(2-i)*C +: C];
			v_c[i]  = side[(2-i)*DW +: DW];
		end
		mag_c = (ovf_c || quotient > LIM) ? LIM : quotient;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= valid_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1: signed beta.
	always_ff @(posedge clk) begin
		if (en) begin
			beta_s1 <= neg_c ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
			kind_s1 <= kind_c;
			for (int i = 0; i < 3; i++) begin
				ob_s1[i] <= ob_c[i];
				v_s1d[i] <= v_c[i];
			end
		end
	end

	// Stage 2: beta times each direction component.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				prod_s2[i] <= beta_s1 * v_s1d[i];
				ob_s2[i]   <= ob_s1[i];
			end
			kind_s2 <= kind_s1;
		end
	end

	// Stage 3 logic: add the origin, saturate, and zero unless a point.
	logic signed [PTW-1:0] sum_c [3];
	logic signed [C-1:0]   sat_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum_c[i] = PTW'(ob_s2[i]) + PTW'(prod_s2[i] >>> F);
			if (sum_c[i] > HI) begin
				sat_c[i] = C'(HI);
			end else if (sum_c[i] < LO) begin
				sat_c[i] = C'(LO);
			end else begin
				sat_c[i] = C'(sum_c[i]);
			end
			if (kind_s2 != KIND_POINT) begin
				sat_c[i] = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pt_s3[i] <= sat_c[i];
			end
			kind_s3 <= kind_s2;
		end
	end

	assign valid_out = v_s3;
	assign kind      = kind_s3;
	assign point     = pt_s3;

endmodule

>>> src/line_line_intersection_3d.sv
// Channel    | Dir | Handshake     | Payload
// line_in    | in  | valid, ready  | a/b origin x,y,z (Q16.16), a/b dir x,y,z (Q1.16)
// result_out | out | valid, ready  | result_kind, point_x, point_y, point_z
// cfg        | in  | valid, ready  | index (0 coplanar, 1 parallel tolerance), data
//
// One line pair is accepted per cycle while the output buffer is not full;
// results leave in order after passing six front stages, the divider that
// resolves two quotient bits a stage, three back stages and the output buffer.
// Reset clears the valid bits, the two-entry output buffer and both
// tolerance registers. The pipeline holds while the output buffer is full;
// it keeps accepting while one result waits. Register writes are always taken.
`include "line_line_intersection_3d_assert.svh"
module line_line_intersection_3d import lli3d_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_D,
	parameter int FRAC_BITS   = FRAC_BITS_D
) (
	input logic              clk,
	input logic              arst_n,
	lli3d_in_if.sink         line_in,
	lli3d_out_if.source      result_out,
	lli3d_cfg_if.sink        cfg
);

	localparam int C    = COORD_WIDTH;
	localparam int F    = FRAC_BITS;
	localparam int DW   = dir_w(F);
	localparam int NUMW = num_w(C, F);
	localparam int DENW = den_w(F);
	localparam int QB   = quo_w(C, F);
	localparam int SW   = side_w(C, F);

	logic [CTOL_W-1:0] ctol_q;
	logic [PTOL_W-1:0] ptol_q;

	// Tolerance registers.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctol_q <= '0;
			ptol_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_COPLANAR_TOL: ctol_q <= cfg.data;
				REG_PARALLEL_TOL: ptol_q <= cfg.data[PTOL_W-1:0];
				default: ;
			endcase
		end
	end

	// The pipeline advances unless the output buffer is full.
	logic [1:0] cnt_q;
	logic       en;

	assign en            = (cnt_q != 2'd2);
	assign line_in.ready = en;

	logic signed [C-1:0]  oa [3];
	logic signed [C-1:0]  ob [3];
	logic signed [DW-1:0] u [3];
	logic signed [DW-1:0] v [3];

	assign oa[0] = line_in.a_origin_x;
	assign oa[1] = line_in.a_origin_y;
	assign oa[2] = line_in.a_origin_z;
	assign ob[0] = line_in.b_origin_x;
	assign ob[1] = line_in.b_origin_y;
	assign ob[2] = line_in.b_origin_z;
	assign u[0]  = line_in.a_dir_x;
	assign u[1]  = line_in.a_dir_y;
	assign u[2]  = line_in.a_dir_z;
	assign v[0]  = line_in.b_dir_x;
	assign v[1]  = line_in.b_dir_y;
	assign v[2]  = line_in.b_dir_z;

	logic            f_valid;
	logic [NUMW-1:0] f_num;
	logic [DENW-1:0] f_den;
	logic [SW-1:0]   f_side;

	lli3d_front #(
		.COORD_WIDTH (C),
		.FRAC_BITS   (F)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (line_in.valid),
		.oa        (oa),
		.ob        (ob),
		.u         (u),
		.v         (v),
		.ctol      (ctol_q),
		.ptol      (ptol_q),
		.valid_out (f_valid),
		.num_mag   (f_num),
		.den_mag   (f_den),
		.side      (f_side)
	);

	logic          d_valid;
	logic [QB-1:0] d_quo;
	logic [SW-1:0] d_side;

	lli3d_div #(
		.NUMW (NUMW),
		.DENW (DENW),
		.QB   (QB),
		.SW   (SW),
		.SPS  (STEPS_PER_STAGE)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (f_valid),
		.dividend  (f_num),
		.divisor   (f_den),
		.side_in   (f_side),
		.valid_out (d_valid),
		.quotient  (d_quo),
		.side_out  (d_side)
	);

	logic                b_valid;
	kind_t               b_kind;
	logic signed [C-1:0] b_point [3];

	lli3d_back #(
		.COORD_WIDTH (C),
		.FRAC_BITS   (F)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (d_valid),
		.quotient  (d_quo),
		.side      (d_side),
		.valid_out (b_valid),
		.kind      (b_kind),
		.point     (b_point)
	);

	// Two-entry output buffer between the pipeline and the result channel.
	kind_t               hold_kind_q [2];
	logic signed [C-1:0] hold_pt_q [2][3];
	logic                head_q, tail_q;
	logic                push, pop;

	assign push = b_valid && en;
	assign pop  = result_out.valid && result_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 2'd0;
			head_q <= 1'b0;
			tail_q <= 1'b0;
		end else begin
			cnt_q  <= cnt_q + 2'(push) - 2'(pop);
			head_q <= head_q ^ pop;
			tail_q <= tail_q ^ push;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			hold_kind_q[tail_q] <= b_kind;
			for (int i = 0; i < 3; i++) begin
				hold_pt_q[tail_q][i] <= b_point[i];
			end
		end
	end

	assign result_out.valid       = (cnt_q != 2'd0);
	assign result_out.result_kind = hold_kind_q[head_q];
	assign result_out.point_x     = hold_pt_q[head_q][0];
	assign result_out.point_y     = hold_pt_q[head_q][1];
	assign result_out.point_z     = hold_pt_q[head_q][2];

	// Checks on the buffer and the result encoding.
	`LLI_ASSERT(a_cnt_range, cnt_q != 2'd3, "output buffer count out of range")
	`LLI_ASSERT(a_kind_code, !result_out.valid || result_out.result_kind != 2'd3, "bad kind")
	`LLI_ASSERT(a_zero_point, !result_out.valid || result_out.result_kind == KIND_POINT || (result_out.point_x == '0 && result_out.point_y == '0 && result_out.point_z == '0), "nonzero point without intersection")
	`LLI_ASSERT_NEXT(a_stall_hold, !en, $stable(b_valid), "pipeline moved while stalled")

endmodule
